>>> rtl/core/waveform_table_player_defines.svh
// Assertion macros shared by the waveform table player checkers.
`ifndef WAVEFORM_TABLE_PLAYER_DEFINES_SVH
`define WAVEFORM_TABLE_PLAYER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define WTP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("waveform table player check failed");

// next-cycle implication, sampled on clock, off during reset
`define WTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("waveform table player check failed");

`endif

>>> rtl/core/wtp_pkg.sv
// Shared types and constants of the waveform table player.
package wtp_pkg;

   localparam int PERIOD_W     = 20;
   localparam int MAX_POINTS_W = 11;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PERIOD_W-1:0]     PERIOD_RESET     = 20'd100;
   localparam logic [MAX_POINTS_W-1:0] MAX_POINTS_RESET = 11'd1024;
   localparam logic                    TARGET_OK_RESET  = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_PERIOD     = 2'd0,
      CSR_MAX_POINTS = 2'd1,
      CSR_TARGET_OK  = 2'd2
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // execute cycle, update result flags
      logic count_dec;
      logic count_reload;
      logic emit;      // read table at play index, flag a sample
      logic advance;
      logic halt;      // clear running and play index
      logic launch;    // set running, play index to zero
      logic store;     // write sample at load count
      logic close;     // point count from load count
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type opcode;
      logic       last;
      logic       running;
      logic       count_expired;
      logic       table_nonempty;
      logic       load_room;
      logic       index_at_end;
   } dp_status_type;

endpackage

>>> rtl/core/waveform_table_player.sv
// Top level of the waveform table player: CSR block, controller and datapath.
//
//   channel   handshake                  payload
//   request   start / busy               req_opcode, req_sample, req_last
//   result    rsp_valid (one cycle)      rsp_out_valid, rsp_out_sample, rsp_playing,
//                                        rsp_position, rsp_point_total
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A request passes through an execute cycle (busy high) in which the
// controller decides the actions and the table RAM is read or written, then a
// result cycle carrying rsp_valid. A new request may be issued in the result
// cycle, but not while busy; the result cycle carries the registered read
// data of the table RAM.
// Reset is synchronous and active high; it clears the controller, counters and
// config registers. Table contents stay undefined until loaded; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module waveform_table_player #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_opcode,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample,
   input  logic                                    req_last,
   // result channel
   output logic                                    rsp_valid,
   output logic                                    rsp_out_valid,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_out_sample,
   output logic                                    rsp_playing,
   output logic [$clog2(TABLE_DEPTH)-1:0]          rsp_position,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]        rsp_point_total,
   // configuration port
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [wtp_pkg::CSR_ADDR_W-1:0]          paddr,
   input  logic [wtp_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [wtp_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   // --- configuration registers ---
   logic [wtp_pkg::PERIOD_W-1:0]     period_ff, period_in;
   logic [wtp_pkg::MAX_POINTS_W-1:0] max_points_ff, max_points_in;
   logic                             target_ok_ff, target_ok_in;
   logic                             csr_write;
   wtp_pkg::csr_index_type           csr_index;

   wtp_pkg::dp_cmd_type    cmd;
   wtp_pkg::dp_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // registers sit on 32-bit words: word index from paddr[3:2]
   assign csr_index = wtp_pkg::csr_index_type'(paddr[3:2]);

   always_comb begin
      period_in     = period_ff;
      max_points_in = max_points_ff;
      target_ok_in  = target_ok_ff;
      if (csr_write) begin
         case (csr_index)
            wtp_pkg::CSR_PERIOD:     period_in     = pwdata[wtp_pkg::PERIOD_W-1:0];
            wtp_pkg::CSR_MAX_POINTS: max_points_in = pwdata[wtp_pkg::MAX_POINTS_W-1:0];
            wtp_pkg::CSR_TARGET_OK:  target_ok_in  = pwdata[0];
            default: begin
               // unmapped word, write ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= wtp_pkg::PERIOD_RESET;
         max_points_ff <= wtp_pkg::MAX_POINTS_RESET;
         target_ok_ff  <= wtp_pkg::TARGET_OK_RESET;
      end else begin
         period_ff     <= period_in;
         max_points_ff <= max_points_in;
         target_ok_ff  <= target_ok_in;
      end
   end

   // readback
   always_comb begin
      case (csr_index)
         wtp_pkg::CSR_PERIOD:     prdata = wtp_pkg::CSR_DATA_W'(period_ff);
         wtp_pkg::CSR_MAX_POINTS: prdata = wtp_pkg::CSR_DATA_W'(max_points_ff);
         wtp_pkg::CSR_TARGET_OK:  prdata = wtp_pkg::CSR_DATA_W'(target_ok_ff);
         default:                 prdata = '0;
      endcase
   end

   // --- controller: idle / execute / result sequencing and action decode ---
   wtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .target_ok (target_ok_ff),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // --- datapath: counters, countdown and the sample table ---
   wtp_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_opcode  (req_opcode),
      .req_sample  (req_sample),
      .req_last    (req_last),
      .period_ms   (period_ff),
      .max_points  (max_points_ff),
      .out_valid   (rsp_out_valid),
      .out_sample  (rsp_out_sample),
      .playing     (rsp_playing),
      .position    (rsp_position),
      .point_total (rsp_point_total)
   );

endmodule

>>> rtl/core/wtp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module wtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wtp_ctrl.sv
// Controller state machine: sequences a request and decides its actions.
module wtp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   target_ok,
   input  wtp_pkg::dp_status_type status,
   output wtp_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic is_tick, is_load, is_start, is_stop;
   logic start_ok, beat_active, exec;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = (state_ff == ST_RESP);
   assign exec      = busy;

   assign is_tick  = (status.opcode == wtp_pkg::OP_TICK);
   assign is_load  = (status.opcode == wtp_pkg::OP_LOAD);
   assign is_start = (status.opcode == wtp_pkg::OP_START);
   assign is_stop  = (status.opcode == wtp_pkg::OP_STOP);

   // start beats at once; a tick beats when the countdown runs out
   assign start_ok    = is_start && !status.running && status.table_nonempty;
   assign beat_active = (is_tick && status.count_expired && status.running) || start_ok;

   always_comb begin
      cmd              = '0;
      cmd.capture      = start && !busy;
      cmd.execute      = exec;
      cmd.count_dec    = exec && is_tick && !status.count_expired;
      cmd.count_reload = exec && ((is_tick && status.count_expired) || start_ok);
      cmd.emit         = exec && beat_active && target_ok;
      cmd.advance      = exec && beat_active && target_ok && !status.index_at_end;
      cmd.halt         = exec && ((beat_active && (!target_ok || status.index_at_end))
                                  || is_stop);
      cmd.launch       = exec && start_ok;
      cmd.store        = exec && is_load && !status.running && status.load_room;
      cmd.close        = exec && is_load && !status.running && status.last;
   end

endmodule

>>> rtl/core/wtp_datapath.sv
// Datapath: request latch, play/load counters, heartbeat countdown, sample table.
module wtp_datapath #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  wtp_pkg::dp_cmd_type                      cmd,
   output wtp_pkg::dp_status_type                   status,
   input  logic [1:0]                               req_opcode,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   input  logic                                     req_last,
   input  logic [wtp_pkg::PERIOD_W-1:0]             period_ms,
   input  logic [wtp_pkg::MAX_POINTS_W-1:0]         max_points,
   output logic                                     out_valid,
   output logic signed [SAMPLE_WIDTH-1:0]           out_sample,
   output logic                                     playing,
   output logic [$clog2(TABLE_DEPTH)-1:0]           position,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]         point_total
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > wtp_pkg::MAX_POINTS_W) ? CNT_W : wtp_pkg::MAX_POINTS_W;

   // request latch (payload)
   wtp_pkg::opcode_type     op_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic                    last_ff;

   // control state
   logic                          running_ff, running_in;
   logic [IDX_W-1:0]              index_ff, index_in;
   logic [CNT_W-1:0]              points_ff, points_in;
   logic [CNT_W-1:0]              loaded_ff, loaded_in;
   logic [wtp_pkg::PERIOD_W-1:0]  countdown_ff, countdown_in;
   logic                          emit_ff, emit_in;

   logic [wtp_pkg::PERIOD_W-1:0]  reload_value;
   logic [CNT_W-1:0]              loaded_inc;
   logic [CNT_W:0]                index_next_ext;
   logic [SAMPLE_WIDTH-1:0]       rd_data;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= wtp_pkg::opcode_type'(req_opcode);
         sample_ff <= req_sample;
         last_ff   <= req_last;
      end
   end

   // zero period behaves as one
   assign reload_value   = (period_ms == '0) ? wtp_pkg::PERIOD_W'(1) : period_ms;
   assign loaded_inc     = loaded_ff + CNT_W'(1);
   assign index_next_ext = (CNT_W+1)'(index_ff) + (CNT_W+1)'(1);

   assign status.opcode         = op_ff;
   assign status.last           = last_ff;
   assign status.running        = running_ff;
   assign status.count_expired  = (countdown_ff <= wtp_pkg::PERIOD_W'(1));
   assign status.table_nonempty = (points_ff != '0);
   assign status.load_room      = (loaded_ff < CNT_W'(TABLE_DEPTH))
                                  && (CMP_W'(loaded_ff) < CMP_W'(max_points));
   assign status.index_at_end   = (index_next_ext >= (CNT_W+1)'(points_ff));

   always_comb begin
      running_in   = running_ff;
      index_in     = index_ff;
      points_in    = points_ff;
      loaded_in    = loaded_ff;
      countdown_in = countdown_ff;
      emit_in      = emit_ff;

      if (cmd.count_reload) begin
         countdown_in = reload_value;
      end else if (cmd.count_dec) begin
         countdown_in = countdown_ff - wtp_pkg::PERIOD_W'(1);
      end

      if (cmd.halt) begin
         running_in = 1'b0;
         index_in   = '0;
      end else begin
         if (cmd.launch) running_in = 1'b1;
         if (cmd.advance) begin
            index_in = index_next_ext[IDX_W-1:0];
         end else if (cmd.launch) begin
            index_in = '0;
         end
      end

      if (cmd.close) begin
         points_in = cmd.store ? loaded_inc : loaded_ff;
         loaded_in = '0;
      end else if (cmd.store) begin
         loaded_in = loaded_inc;
      end

      if (cmd.execute) emit_in = cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         index_ff     <= '0;
         points_ff    <= '0;
         loaded_ff    <= '0;
         countdown_ff <= wtp_pkg::PERIOD_RESET;
         emit_ff      <= 1'b0;
      end else begin
         running_ff   <= running_in;
         index_ff     <= index_in;
         points_ff    <= points_in;
         loaded_ff    <= loaded_in;
         countdown_ff <= countdown_in;
         emit_ff      <= emit_in;
      end
   end

   wtp_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (loaded_ff[IDX_W-1:0]),
      .wr_data (sample_ff),
      .rd_en   (cmd.emit),
      .rd_addr (index_ff),
      .rd_data (rd_data)
   );

   assign out_valid   = emit_ff;
   assign out_sample  = emit_ff ? $signed(rd_data) : '0;
   assign playing     = running_ff;
   assign position    = index_ff;
   assign point_total = points_ff;

endmodule

>>> rtl/core/wtp_checker.sv
// Port-level checker for the waveform table player, bound to the top level.
`include "waveform_table_player_defines.svh"

module wtp_checker #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic                               rsp_out_valid,
   input logic signed [SAMPLE_WIDTH-1:0]     rsp_out_sample,
   input logic                               rsp_playing,
   input logic [$clog2(TABLE_DEPTH)-1:0]     rsp_position
);

   // an accepted request is followed by its execute cycle
   `WTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // the execute cycle is always followed by its result
   `WTP_ASSERT_NEXT(a_busy_result, busy, rsp_valid && !busy)
   // no emitted sample means a zero sample field
   `WTP_ASSERT_SAME(a_quiet_sample, rsp_valid && !rsp_out_valid, rsp_out_sample == '0)
   // idle player reports position zero
   `WTP_ASSERT_SAME(a_idle_position, rsp_valid && !rsp_playing, rsp_position == '0)

endmodule

bind waveform_table_player wtp_checker #(
   .TABLE_DEPTH  (TABLE_DEPTH),
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wtp_checker (.*);

>>> test/tb_waveform_table_player.sv
`timescale 1ns / 1ps
// Self-checking testbench for waveform_table_player: directed, then random requests.
module tb_waveform_table_player;
   import wtp_pkg::*;

   localparam int TBL_DEPTH   = 1024;
   localparam int CYCLE_LIMIT = 200000;

   // one request as planned by the stimulus
   typedef struct {
      opcode_type         op;
      logic signed [31:0] smp;
      logic               lst;
      bit                 drain_first;   // hold off until nothing is outstanding
   } player_req_t;

   // one predicted result
   typedef struct {
      logic               emit;
      logic signed [31:0] dac_word;
      logic               playing;
      logic [9:0]         position;
      logic [10:0]        point_total;
   } player_rsp_t;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  busy;
   logic [1:0]            req_opcode = OP_TICK;
   logic signed [31:0]    req_sample = '0;
   logic                  req_last   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_out_valid;
   logic signed [31:0]    rsp_out_sample;
   logic                  rsp_playing;
   logic [9:0]            rsp_position;
   logic [10:0]           rsp_point_total;
   logic                  psel       = 1'b0;
   logic                  penable    = 1'b0;
   logic                  pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr      = '0;
   logic [CSR_DATA_W-1:0] pwdata     = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // ------------------------------------------------------- player prediction
   logic signed [31:0]      tbl_mem [TBL_DEPTH];
   bit                      run_flag  = 1'b0;
   int                      play_pos  = 0;
   int                      pts       = 0;
   int                      loaded    = 0;
   int                      countdown = int'(PERIOD_RESET);
   logic [PERIOD_W-1:0]     cfg_period  = PERIOD_RESET;
   logic [MAX_POINTS_W-1:0] cfg_max_pts = MAX_POINTS_RESET;
   logic                    cfg_target  = TARGET_OK_RESET;

   player_req_t req_plan [$];   // every request, in issue order
   player_rsp_t rsp_due  [$];   // predicted results not yet seen

   int issue_idx    = 0;   // next entry of req_plan to drive
   int sent_cnt     = 0;   // requests accepted
   int seen_cnt     = 0;   // results observed
   int gap_left     = 0;
   int mismatch_cnt = 0;
   int cycle_cnt    = 0;
   bit calm         = 1'b0;   // no sender gaps in the closing phase

   waveform_table_player dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_sample      (req_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_playing     (rsp_playing),
      .rsp_position    (rsp_position),
      .rsp_point_total (rsp_point_total),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One heartbeat: emit the sample at the play index if the target is valid.
   function automatic void heartbeat(output logic fired, output logic signed [31:0] word);
      fired = 1'b0;
      word  = '0;
      if (run_flag) begin
         if (!cfg_target || play_pos >= TBL_DEPTH) begin
            // invalid target: play ends, nothing goes out
            run_flag = 1'b0;
            play_pos = 0;
         end else begin
            fired = 1'b1;
            word  = tbl_mem[play_pos];
            play_pos++;
            if (play_pos >= pts) begin
               run_flag = 1'b0;
               play_pos = 0;
            end
         end
      end
   endfunction

   // Apply one accepted request to the player state and queue its result.
   function automatic void player_advance(opcode_type op, logic signed [31:0] smp,
                                          logic lst);
      player_rsp_t r;
      int          reload_ms;
      int          keep_lim;
      reload_ms  = (cfg_period == '0) ? 1 : int'(cfg_period);   // zero period acts as one
      keep_lim   = (int'(cfg_max_pts) < TBL_DEPTH) ? int'(cfg_max_pts) : TBL_DEPTH;
      r.emit     = 1'b0;
      r.dac_word = '0;
      case (op)
         OP_TICK: begin
            if (countdown <= 1) begin
               countdown = reload_ms;
               heartbeat(r.emit, r.dac_word);
            end else begin
               countdown--;
            end
         end
         OP_LOAD: begin
            // dropped entirely while playing, last mark included
            if (!run_flag) begin
               if (loaded < keep_lim) begin
                  tbl_mem[loaded] = smp;
                  loaded++;
               end
               // last closes the table even when its sample was dropped
               if (lst) begin
                  pts    = loaded;
                  loaded = 0;
               end
            end
         end
         OP_START: begin
            if (!run_flag && pts > 0) begin
               run_flag  = 1'b1;
               play_pos  = 0;
               countdown = reload_ms;
               heartbeat(r.emit, r.dac_word);   // first sample goes out at once
            end
         end
         OP_STOP: begin
            run_flag = 1'b0;
            play_pos = 0;
         end
      endcase
      r.playing     = run_flag;
      r.position    = run_flag ? 10'(play_pos) : '0;
      r.point_total = 11'(pts);
      rsp_due.push_back(r);
   endfunction

   task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         log_mismatch(name, want, got);
   endtask

   // ----------------------------------------------------------------- driver
   // Requests come from req_plan. After an accepted request the sender may go
   // quiet unless calm is set; a request marked drain_first waits until every
   // result already due has come back.
   always @(posedge clock) begin : drive_requests
      logic took;
      int   gap;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         took = start && !busy;
         gap  = gap_left;
         if (took) begin
            player_advance(opcode_type'(req_opcode), req_sample, req_last);
            sent_cnt <= sent_cnt + 1;
            if (!calm && $urandom_range(0, 5) == 0)
               gap = $urandom_range(1, 5);
         end
         if (!start || took) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (issue_idx < req_plan.size() &&
                         (!req_plan[issue_idx].drain_first ||
                          (!start && sent_cnt == seen_cnt))) begin
               start      <= 1'b1;
               req_opcode <= req_plan[issue_idx].op;
               req_sample <= req_plan[issue_idx].smp;
               req_last   <= req_plan[issue_idx].lst;
               issue_idx  <= issue_idx + 1;
            end else begin
               start <= 1'b0;
            end
         end
         gap_left <= gap;
      end
   end

   // ---------------------------------------------------------------- monitor
   // Results cannot be held off; each one is compared with the oldest prediction.
   always @(posedge clock) begin : watch_results
      player_rsp_t want;
      if (!reset && rsp_valid !== 1'b0) begin
         seen_cnt <= seen_cnt + 1;
         if (rsp_due.size() == 0) begin
            log_mismatch("result with none due", '0, 32'(rsp_valid));
         end else begin
            want = rsp_due.pop_front();
            check_field("out_valid",   32'(want.emit),        32'(rsp_out_valid));
            check_field("out_sample",  want.dac_word,         rsp_out_sample);
            check_field("playing",     32'(want.playing),     32'(rsp_playing));
            check_field("position",    32'(want.position),    32'(rsp_position));
            check_field("point_total", 32'(want.point_total), 32'(rsp_point_total));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("** waveform_table_player: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------- stimulus
   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_req(opcode_type op, logic signed [31:0] smp, logic lst,
                                   bit drain = 1'b0);
      player_req_t q;
      q.op          = op;
      q.smp         = smp;
      q.lst         = lst;
      q.drain_first = drain;
      req_plan.push_back(q);
   endfunction

   // Mostly well-formed sequences: load a short table, start, tick it out,
   // with stray loads, starts and stops mixed in; the rest is random requests.
   function automatic void plan_phase(int budget);
      int added;
      int n;
      int k;
      int ticks;
      int eff;
      bit drain;
      added = 0;
      eff   = (cfg_period == '0) ? 1 : int'(cfg_period);
      while (added < budget) begin
         drain = ($urandom_range(0, 24) == 0);
         if ($urandom_range(0, 9) < 6) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (k = 0; k < n; k++)
               add_req(OP_LOAD, rand_word(), k == n - 1, drain && k == 0);
            add_req(OP_START, rand_word(), 1'($urandom_range(0, 1)));
            ticks = (eff > 8) ? $urandom_range(2, 12) : n * eff + $urandom_range(0, 3);
            for (k = 0; k < ticks; k++) begin
               if ($urandom_range(0, 15) == 0) begin
                  add_req(opcode_type'($urandom_range(1, 3)), rand_word(),
                          1'($urandom_range(0, 1)));
                  added++;
               end
               add_req(OP_TICK, rand_word(), 1'($urandom_range(0, 1)));
            end
            added += n + 1 + ticks;
         end else begin
            add_req(opcode_type'($urandom_range(0, 3)), rand_word(),
                    $urandom_range(0, 3) == 0, drain);
            added++;
         end
      end
   endfunction

   // APB write, then read back; bits above the field are filled with junk.
   task automatic csr_set(csr_index_type idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] bus_word;
      case (idx)
         CSR_PERIOD:     mask = 32'h000F_FFFF;
         CSR_MAX_POINTS: mask = 32'h0000_07FF;
         default:        mask = 32'h0000_0001;
      endcase
      bus_word = (value & mask) | ($urandom() & ~mask);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= bus_word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         CSR_PERIOD:     cfg_period  = bus_word[PERIOD_W-1:0];
         CSR_MAX_POINTS: cfg_max_pts = bus_word[MAX_POINTS_W-1:0];
         default:        cfg_target  = bus_word[0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      check_field("csr readback", bus_word & mask, prdata & mask);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(int period, int max_pts, logic target);
      csr_set(CSR_PERIOD, period);
      csr_set(CSR_MAX_POINTS, max_pts);
      csr_set(CSR_TARGET_OK, 32'(target));
   endtask

   // Block is idle once everything planned was accepted and answered.
   task automatic wait_idle();
      do @(posedge clock);
      while (issue_idx != req_plan.size() || start || sent_cnt != seen_cnt);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(int period, int max_pts, logic target, int budget);
      set_config(period, max_pts, target);
      plan_phase(budget);
      wait_idle();
   endtask

   initial begin : stimulus
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: period of one tick so every tick is a beat
      set_config(1, 1024, 1'b1);
      add_req(OP_STOP,  rand_word(), 1'b1);          // stop while idle
      add_req(OP_START, rand_word(), 1'b0);          // empty table, start ignored
      add_req(OP_TICK,  rand_word(), 1'b1);          // tick with nothing playing
      add_req(OP_LOAD,  32'h8000_0000, 1'b0);
      add_req(OP_LOAD,  32'h7FFF_FFFF, 1'b0);
      add_req(OP_LOAD,  32'hFFFF_FFFF, 1'b1);        // closes a 3-point table
      add_req(OP_START, rand_word(), 1'b0);          // first sample at once
      add_req(OP_LOAD,  32'h1234_5678, 1'b1);        // load while playing: dropped
      add_req(OP_START, rand_word(), 1'b1);          // start while playing: ignored
      add_req(OP_TICK,  rand_word(), 1'b0);
      add_req(OP_TICK,  rand_word(), 1'b0);          // final point, play ends
      add_req(OP_TICK,  rand_word(), 1'b0);
      add_req(OP_START, rand_word(), 1'b0);
      add_req(OP_STOP,  rand_word(), 1'b0);          // stop mid-play
      add_req(OP_LOAD,  32'h0000_0000, 1'b1, 1'b1);  // one-point table, sent once drained
      add_req(OP_START, rand_word(), 1'b0);          // emitted and done in one request
      add_req(OP_LOAD,  32'h5A5A_5A5A, 1'b0);        // partial load left open
      add_req(OP_START, rand_word(), 1'b0);          // plays old table, load untouched
      add_req(OP_LOAD,  32'hA5A5_A5A5, 1'b1);        // partial load closes at two points
      add_req(OP_START, rand_word(), 1'b0);
      add_req(OP_TICK,  rand_word(), 1'b1);
      wait_idle();

      run_phase(2, 1024, 1'b1, 100);
      run_phase(0, 3, 1'b1, 120);                    // zero period, truncated loads
      run_phase(1, 0, 1'b1, 40);                     // nothing kept, tables empty
      run_phase(3, 2047, 1'b0, 60);                  // invalid target ends play

      run_phase(20'hF_FFFF, 1, 1'b1, 40);            // longest period, one point
      for (k = 0; k < 3; k++)
         run_phase($urandom_range(1, 4), $urandom_range(1, 16), $urandom_range(0, 3) != 0, 70);

      calm = 1'b1;
      run_phase(1, 1024, 1'b1, 100);

      repeat (10) @(posedge clock);   // catch stray results
      if (rsp_due.size() != 0)
         log_mismatch("results never seen", 32'(rsp_due.size()), '0);
      if (mismatch_cnt == 0)
         $display("** waveform_table_player: PASSED **");
      else
         $display("** waveform_table_player: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wtp_pkg.sv
rtl/core/wtp_ram.sv
rtl/core/wtp_ctrl.sv
rtl/core/wtp_datapath.sv
rtl/core/waveform_table_player.sv
rtl/core/wtp_checker.sv
test/tb_waveform_table_player.sv
